// ===== rtl/sorted_set_table_assert.svh =====
// Assertion macros for the sorted set table checker.
// Needs nothing else; included by the checker file.
`ifndef SORTED_SET_TABLE_ASSERT_SVH
`define SORTED_SET_TABLE_ASSERT_SVH

// Same-cycle implication, checked outside reset.
`define SST_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("sorted_set_table: assertion failed");

// Next-cycle implication, checked outside reset.
`define SST_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("sorted_set_table: assertion failed");

`endif

// ===== rtl/sst_pkg.sv =====
// Shared constants and types for the sorted set table.
// Used by sst_cell, sorted_set_table and sst_checker.
package sst_pkg;

    localparam int CAPACITY_DEF    = 64;
    localparam int VALUE_WIDTH_DEF = 32;

    // Port widths
    localparam int MODE_W   = 3;
    localparam int VALUE_W  = 32;
    localparam int INDEX_W  = 6;
    localparam int COUNT_W  = 7;
    localparam int STATUS_W = 2;

    // Operation codes
    localparam logic [MODE_W-1:0] MODE_INSERT = 3'd0;
    localparam logic [MODE_W-1:0] MODE_ERASE  = 3'd1;
    localparam logic [MODE_W-1:0] MODE_LOOKUP = 3'd2;
    localparam logic [MODE_W-1:0] MODE_READ   = 3'd3;
    localparam logic [MODE_W-1:0] MODE_CLEAR  = 3'd4;

    // Status codes
    localparam logic [STATUS_W-1:0] ST_DONE   = 2'd0;
    localparam logic [STATUS_W-1:0] ST_FULL   = 2'd1;
    localparam logic [STATUS_W-1:0] ST_ABSENT = 2'd2;
    localparam logic [STATUS_W-1:0] ST_DUP    = 2'd3;

    // Shift commands broadcast to every cell
    typedef struct packed {
        logic shift_up;    // insert: open a gap at the insert point
        logic shift_down;  // erase: close the gap at the match
    } t_cell_ctrl;

    // Per-cell compare results
    typedef struct packed {
        logic lt;   // holds a valid entry below the probe value
        logic eq;   // holds a valid entry equal to the probe value
        logic sel;  // valid and at the requested read index
    } t_cell_flags;

endpackage

// ===== rtl/sst_cell.sv =====
// One table position: stores an entry, compares it with the probe value
// and takes a neighbor's entry on shifts. Depends on sst_pkg.
module sst_cell #(
    parameter int IDX = 0,
    parameter int SW  = 32,
    parameter int CW  = 7,
    parameter int IW  = 6
) (
    input  logic                     i_clk,
    input  sst_pkg::t_cell_ctrl      i_ctrl,
    input  logic [SW-1:0]            i_value,
    input  logic [IW-1:0]            i_index,
    input  logic [CW-1:0]            i_count,
    input  logic                     i_left_lt,
    input  logic [SW-1:0]            i_left_entry,
    input  logic [SW-1:0]            i_right_entry,
    output logic [SW-1:0]            o_entry,
    output sst_pkg::t_cell_flags     o_flags
);

    localparam bit IDX_REACH = (IDX < (1 << IW));

    logic [SW-1:0] r_entry;
    logic [SW-1:0] n_entry;
    logic          valid;

    assign valid         = (i_count > CW'(IDX));
    assign o_flags.lt    = valid && (r_entry < i_value);
    assign o_flags.eq    = valid && (r_entry == i_value);
    assign o_flags.sel   = IDX_REACH && valid && (i_index == IW'(IDX));
    assign o_entry       = r_entry;

    // Sorted order makes lt a prefix over the row: !lt marks the insert
    // point and everything above it.
    always_comb begin
        n_entry = r_entry;
        priority if (i_ctrl.shift_up) begin
            if (!o_flags.lt) begin
                n_entry = i_left_lt ? i_value : i_left_entry;
            end
        end else if (i_ctrl.shift_down) begin
            if (!o_flags.lt) begin
                n_entry = i_right_entry;
            end
        end else begin
            n_entry = r_entry;
        end
    end

    always_ff @(posedge i_clk) begin
        r_entry <= n_entry;
    end

endmodule

// ===== rtl/sorted_set_table.sv =====
// Top level of the sorted set table: a row of sst_cell positions plus
// count, control and result registers. Depends on sst_pkg and sst_cell.
//
// Usage
//   Command channel: drive i_mode, i_value, i_index and raise start. The
//   transfer happens at a rising edge where start is high and busy is low.
//   Modes: insert, erase, lookup, read at index, clear.
//   Result channel: o_valid is high for exactly one cycle, the cycle after
//   the command transfer, carrying o_hit, o_read_value, o_count,
//   o_is_empty and o_status. The receiver cannot stall; it must take the
//   result in that cycle.
//   Throughput: 1 command per cycle while busy is low. Every cell compares
//   the probe value against its entry in parallel, and the whole row shifts
//   by one place in the same edge, so the single compare/shift pass through
//   the cell row sets the rate.
//   Reset (i_rst_n low, synchronous): count goes to zero, the result strobe
//   drops, and busy stays high until the ready register is set after release.
//   Entry contents are not cleared; positions at or above the count are
//   never reported.
//   Values are kept at VALUE_WIDTH bits (at most 32); upper input bits
//   are ignored and read data is zero-extended.
module sorted_set_table #(
    parameter int CAPACITY    = sst_pkg::CAPACITY_DEF,
    parameter int VALUE_WIDTH = sst_pkg::VALUE_WIDTH_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          start,
    output logic                          busy,
    input  logic [sst_pkg::MODE_W-1:0]    i_mode,
    input  logic [sst_pkg::VALUE_W-1:0]   i_value,
    input  logic [sst_pkg::INDEX_W-1:0]   i_index,
    output logic                          o_valid,
    output logic                          o_hit,
    output logic [sst_pkg::VALUE_W-1:0]   o_read_value,
    output logic [sst_pkg::COUNT_W-1:0]   o_count,
    output logic                          o_is_empty,
    output logic [sst_pkg::STATUS_W-1:0]  o_status
);

    // Stored width: value field is 32 bits, so wider settings add nothing.
    localparam int SW = (VALUE_WIDTH < sst_pkg::VALUE_W) ? VALUE_WIDTH : sst_pkg::VALUE_W;
    localparam int CW = $clog2(CAPACITY + 1);
    localparam int IW = sst_pkg::INDEX_W;

    logic                   r_ready;
    logic [CW-1:0]          r_count;
    logic [CW-1:0]          n_count;

    // Result register
    logic                            r_valid;
    logic                            r_hit;
    logic [SW-1:0]                   r_rd;
    logic [sst_pkg::STATUS_W-1:0]    r_status;

    logic                            accept;
    logic [SW-1:0]                   probe;
    logic                            full;
    logic                            hit;
    logic                            idx_ok;
    logic [SW-1:0]                   rd;
    logic [sst_pkg::STATUS_W-1:0]    status;
    sst_pkg::t_cell_ctrl             ctrl;

    logic [SW-1:0]                   entry [CAPACITY];
    sst_pkg::t_cell_flags            flags [CAPACITY];

    assign busy   = ~r_ready;
    assign accept = start && r_ready;
    assign probe  = i_value[SW-1:0];
    assign full   = (r_count == CW'(CAPACITY));

    // Cell row: each position talks to its two neighbors only
    for (genvar k = 0; k < CAPACITY; k++) begin : g_cell
        logic          left_lt;
        logic [SW-1:0] left_entry;
        logic [SW-1:0] right_entry;

        if (k == 0) begin : g_first
            assign left_lt    = 1'b1;
            assign left_entry = probe;
        end else begin : g_mid
            assign left_lt    = flags[k-1].lt;
            assign left_entry = entry[k-1];
        end

        if (k == CAPACITY - 1) begin : g_last
            assign right_entry = entry[k];
        end else begin : g_inner
            assign right_entry = entry[k+1];
        end

        sst_cell #(
            .IDX (k),
            .SW  (SW),
            .CW  (CW),
            .IW  (IW)
        ) u_cell (
            .i_clk         (i_clk),
            .i_ctrl        (ctrl),
            .i_value       (probe),
            .i_index       (i_index),
            .i_count       (r_count),
            .i_left_lt     (left_lt),
            .i_left_entry  (left_entry),
            .i_right_entry (right_entry),
            .o_entry       (entry[k]),
            .o_flags       (flags[k])
        );
    end

    // Gather match and read bus across the row (one-hot per bus)
    always_comb begin
        hit    = 1'b0;
        idx_ok = 1'b0;
        rd     = '0;
        for (int k = 0; k < CAPACITY; k++) begin
            hit    = hit | flags[k].eq;
            idx_ok = idx_ok | flags[k].sel;
            rd     = rd | ({SW{flags[k].sel}} & entry[k]);
        end
    end

    // Shift commands; duplicate check wins over full check
    always_comb begin
        ctrl.shift_up   = accept && (i_mode == sst_pkg::MODE_INSERT) && !hit && !full;
        ctrl.shift_down = accept && (i_mode == sst_pkg::MODE_ERASE) && hit;
    end

    always_comb begin
        n_count = r_count;
        priority if (ctrl.shift_up) begin
            n_count = r_count + CW'(1);
        end else if (ctrl.shift_down) begin
            n_count = r_count - CW'(1);
        end else if (accept && (i_mode == sst_pkg::MODE_CLEAR)) begin
            n_count = '0;
        end else begin
            n_count = r_count;
        end
    end

    always_comb begin
        unique case (i_mode)
            sst_pkg::MODE_INSERT: begin
                if (hit) begin
                    status = sst_pkg::ST_DUP;
                end else if (full) begin
                    status = sst_pkg::ST_FULL;
                end else begin
                    status = sst_pkg::ST_DONE;
                end
            end
            sst_pkg::MODE_ERASE: begin
                status = hit ? sst_pkg::ST_DONE : sst_pkg::ST_ABSENT;
            end
            sst_pkg::MODE_READ: begin
                status = idx_ok ? sst_pkg::ST_DONE : sst_pkg::ST_DUP;
            end
            default: begin
                status = sst_pkg::ST_DONE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ready <= 1'b0;
            r_count <= '0;
            r_valid <= 1'b0;
        end else begin
            r_ready <= 1'b1;
            r_count <= n_count;
            r_valid <= accept;
        end
    end

    // Result payload, no reset needed
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_hit    <= hit;
            r_rd     <= ((i_mode == sst_pkg::MODE_READ) && idx_ok) ? rd : '0;
            r_status <= status;
        end
    end

    // r_count already holds the post-operation count in the strobe cycle
    assign o_valid      = r_valid;
    assign o_hit        = r_hit;
    assign o_read_value = sst_pkg::VALUE_W'(r_rd);
    assign o_count      = sst_pkg::COUNT_W'(r_count);
    assign o_is_empty   = (r_count == '0);
    assign o_status     = r_status;

endmodule

// ===== rtl/sst_checker.sv =====
// Port-level checker for sorted_set_table, attached by bind.
// Depends on sst_pkg and sorted_set_table_assert.svh.
`include "sorted_set_table_assert.svh"

module sst_checker (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          start,
    input  logic                          busy,
    input  logic [sst_pkg::MODE_W-1:0]    i_mode,
    input  logic                          o_valid,
    input  logic                          o_hit,
    input  logic [sst_pkg::VALUE_W-1:0]   o_read_value,
    input  logic [sst_pkg::STATUS_W-1:0]  o_status
);

    logic accept;
    assign accept = start && !busy;

    // Every command transfer yields a result strobe in the next cycle
    `SST_ASSERT_NEXT(a_result_follows, i_clk, i_rst_n, accept, o_valid)

    // Absent erase means the value was not present
    `SST_ASSERT_NOW(a_absent_no_hit, i_clk, i_rst_n, o_valid && (o_status == sst_pkg::ST_ABSENT), !o_hit)

    // Full-drop status only when the value was not already present
    `SST_ASSERT_NOW(a_full_no_hit, i_clk, i_rst_n, o_valid && (o_status == sst_pkg::ST_FULL), !o_hit)

    // Read data is zero outside read commands
    `SST_ASSERT_NOW(a_rd_only_read, i_clk, i_rst_n, o_valid && ($past(i_mode) != sst_pkg::MODE_READ), o_read_value == '0)

endmodule

bind sorted_set_table sst_checker u_sst_checker (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .start        (start),
    .busy         (busy),
    .i_mode       (i_mode),
    .o_valid      (o_valid),
    .o_hit        (o_hit),
    .o_read_value (o_read_value),
    .o_status     (o_status)
);
